@@ rtl/efr_pkg.sv @@
// Shared constants, types and helper functions of the escaped frame receiver.
package efr_pkg;

  localparam int unsigned MaxFrameDefault = 255;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AddrW   = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OutDataW = 48;  // 43 field bits padded to whole bytes

  // Framing characters
  localparam logic [ByteW-1:0] ChOpen   = 8'h40;  // '@'
  localparam logic [ByteW-1:0] ChClose  = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] ChEsc    = 8'h5E;  // '^'
  localparam logic [ByteW-1:0] ChEOpen  = 8'h7B;  // '{'
  localparam logic [ByteW-1:0] ChEClose = 8'h7D;  // '}'
  localparam logic [ByteW-1:0] ChEEsc   = 8'h23;  // '#'

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCrcPoly = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCrcInit = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOwnAddr = 2'd2;

  localparam logic [ByteW-1:0] CrcPolyReset = 8'h07;
  localparam logic [ByteW-1:0] CrcInitReset = 8'h00;
  localparam logic [AddrW-1:0] OwnAddrReset = 24'h47534D;  // "GSM"

  typedef enum logic [StatusW-1:0] {
    StOk        = 3'd0,
    StCrcErr    = 3'd1,
    StBadHex    = 3'd2,
    StWrongAddr = 3'd3,
    StEscErr    = 3'd4,
    StRestart   = 3'd5,
    StTooShort  = 3'd6,
    StOverflow  = 3'd7
  } status_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindEnd     = 1'b1
  } kind_e;

  // MSB-first CRC-8 byte update, implicit x^8 term
  function automatic logic [ByteW-1:0] crc_fold(input logic [ByteW-1:0] crc,
                                                input logic [ByteW-1:0] data,
                                                input logic [ByteW-1:0] poly);
    logic [ByteW-1:0] r;
    r = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (r[ByteW-1]) begin
        r = {r[ByteW-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[ByteW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // ASCII hex digit to nibble; bit 4 set flags a non-hex character
  function automatic logic [4:0] hex_value(input logic [ByteW-1:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h57)};
    end
    return v;
  endfunction

endpackage

@@ rtl/escaped_frame_receiver_crc8.sv @@
// Byte-stuffed frame receiver with CRC-8 check and payload streaming.
//
// Slave stream: one received character per word on s_axis_tdata. Characters
// outside a frame are dropped; '@' opens a frame and ';' closes it, '^'
// escapes the next character. Master stream: tuser gives the kind of word,
// 0 for a payload byte of the open frame, 1 for the frame end status with
// sender and computed CRC. Payload bytes leave two characters late, so the
// trailing hex digits are never sent out.
// Configuration channel: cfg_index_i 0 polynomial, 1 CRC start value,
// 2 own address; it is always ready and must be written only while the block
// is idle, which the block itself does not enforce. Throughput: one character
// per cycle unless the master side stalls; decode, CRC byte update and frame
// checks sit in one stage ahead of the output register.
// The slave side stays ready while the output register is empty or being
// taken; a stalled master side holds the result and stalls the slave side.
// Reset clears the framing state, empties the output register and loads
// the register defaults (polynomial 0x07, start 0x00, address "GSM").
module escaped_frame_receiver_crc8 #(
  parameter int unsigned MaxFrame = efr_pkg::MaxFrameDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [efr_pkg::ByteW-1:0]      s_axis_tdata,   // [7:0] rx_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [34:11] sender, [42:35] computed_crc
  output logic [efr_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tuser,   // [0] kind
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [efr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [efr_pkg::AddrW-1:0]      cfg_data_i
);

  localparam int unsigned LenW = $clog2(MaxFrame + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxFrame);

  logic [efr_pkg::ByteW-1:0] poly_q, init_q;
  logic [efr_pkg::AddrW-1:0] own_q;

  logic                      in_frame_q, in_frame_d;
  logic                      esc_q, esc_d;
  logic [LenW-1:0]           len_q, len_d;
  logic [efr_pkg::ByteW-1:0] dly0_q, dly0_d, dly1_q, dly1_d;
  logic [efr_pkg::ByteW-1:0] crc_q, crc_d;
  logic [efr_pkg::AddrW-1:0] snd_q, snd_d, rcp_q, rcp_d;

  logic                      out_valid_q;
  logic [efr_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                      out_kind_q, out_kind_d;

  logic                      in_hs;
  logic                      emit;
  logic                      take;
  logic [efr_pkg::ByteW-1:0] take_byte;
  efr_pkg::status_e          st;
  logic [4:0]                hex_hi, hex_lo;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  assign hex_hi = efr_pkg::hex_value(dly1_q);
  assign hex_lo = efr_pkg::hex_value(dly0_q);

  // Frame decode for the word on the slave side
  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    len_d      = len_q;
    dly0_d     = dly0_q;
    dly1_d     = dly1_q;
    crc_d      = crc_q;
    snd_d      = snd_q;
    rcp_d      = rcp_q;
    emit       = 1'b0;
    take       = 1'b0;
    take_byte  = s_axis_tdata;
    st         = efr_pkg::StOk;
    out_kind_d = efr_pkg::KindEnd;
    out_data_d = '0;

    if (!in_frame_q) begin
      if (s_axis_tdata == efr_pkg::ChOpen) begin
        in_frame_d = 1'b1;
      end
    end else if (s_axis_tdata == efr_pkg::ChOpen) begin
      emit = 1'b1;
      st   = efr_pkg::StRestart;
    end else if (s_axis_tdata == efr_pkg::ChClose) begin
      emit       = 1'b1;
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
      if (esc_q) begin
        st = efr_pkg::StEscErr;
      end else if (len_q < LenW'(8)) begin
        st = efr_pkg::StTooShort;
      end else if (hex_hi[4] || hex_lo[4]) begin
        st = efr_pkg::StBadHex;
      end else if ({hex_hi[3:0], hex_lo[3:0]} != crc_q) begin
        st = efr_pkg::StCrcErr;
      end else if (rcp_q != own_q) begin
        st = efr_pkg::StWrongAddr;
      end
    end else if (esc_q) begin
      esc_d = 1'b0;
      case (s_axis_tdata)
        efr_pkg::ChEOpen:  take_byte = efr_pkg::ChOpen;
        efr_pkg::ChEClose: take_byte = efr_pkg::ChClose;
        efr_pkg::ChEEsc:   take_byte = efr_pkg::ChEsc;
        default:           take_byte = s_axis_tdata;
      endcase
      if (s_axis_tdata == efr_pkg::ChEOpen || s_axis_tdata == efr_pkg::ChEClose ||
          s_axis_tdata == efr_pkg::ChEEsc) begin
        take = 1'b1;
      end else begin
        emit       = 1'b1;
        st         = efr_pkg::StEscErr;
        in_frame_d = 1'b0;
      end
    end else if (s_axis_tdata == efr_pkg::ChEsc) begin
      esc_d = 1'b1;
    end else begin
      take = 1'b1;
    end

    if (take) begin
      if (len_q >= MaxLen) begin
        emit       = 1'b1;
        st         = efr_pkg::StOverflow;
        in_frame_d = 1'b0;
      end else begin
        if (len_q < LenW'(3)) begin
          snd_d = {snd_q[efr_pkg::AddrW-9:0], take_byte};
        end else if (len_q < LenW'(6)) begin
          rcp_d = {rcp_q[efr_pkg::AddrW-9:0], take_byte};
        end
        if (len_q >= LenW'(2)) begin
          crc_d = efr_pkg::crc_fold(crc_q, dly1_q, poly_q);
          if (len_q >= LenW'(8)) begin
            emit       = 1'b1;
            out_kind_d = efr_pkg::KindPayload;
            out_data_d = {40'h0, dly1_q};
          end
        end
        dly1_d = dly0_q;
        dly0_d = take_byte;
        len_d  = len_q + LenW'(1);
      end
    end

    if (emit && out_kind_d == efr_pkg::KindEnd) begin
      out_data_d = {5'h0, crc_q, snd_q, st, 8'h00};
    end

    // Open a fresh frame, also on restart
    if (s_axis_tdata == efr_pkg::ChOpen) begin
      in_frame_d = 1'b1;
      esc_d      = 1'b0;
      len_d      = '0;
      dly0_d     = '0;
      dly1_d     = '0;
      crc_d      = init_q;
      snd_d      = '0;
      rcp_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= efr_pkg::CrcPolyReset;
      init_q <= efr_pkg::CrcInitReset;
      own_q  <= efr_pkg::OwnAddrReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        efr_pkg::RegCrcPoly: poly_q <= cfg_data_i[efr_pkg::ByteW-1:0];
        efr_pkg::RegCrcInit: init_q <= cfg_data_i[efr_pkg::ByteW-1:0];
        efr_pkg::RegOwnAddr: own_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      len_q      <= '0;
      dly0_q     <= '0;
      dly1_q     <= '0;
      crc_q      <= efr_pkg::CrcInitReset;
      snd_q      <= '0;
      rcp_q      <= '0;
    end else if (in_hs) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      len_q      <= len_d;
      dly0_q     <= dly0_d;
      dly1_q     <= dly1_d;
      crc_q      <= crc_d;
      snd_q      <= snd_d;
      rcp_q      <= rcp_d;
    end
  end

  // Output register: load a new word, or drop the one just taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_hs && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs && emit) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
    end
  end

  a_esc_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> in_frame_q)
    else $error("escape pending outside a frame");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MaxLen)
    else $error("frame length beyond maximum");

  a_hunt_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_hs && !in_frame_q && s_axis_tdata != efr_pkg::ChOpen) |=>
      (!in_frame_q && $stable(len_q)))
    else $error("character outside a frame changed state");

  a_close_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_hs && in_frame_q && s_axis_tdata == efr_pkg::ChClose) |=>
      (!in_frame_q && m_axis_tvalid && m_axis_tuser == efr_pkg::KindEnd))
    else $error("frame close gave no status word");

endmodule
